FILE: sv/m3au_pkg.sv
// ---------------------------------------------------------------------------
// m3au_pkg: shared definitions for the 3x3 matrix arithmetic unit
// Word format, item and operation codes, saturation and indexing helpers.
// ---------------------------------------------------------------------------
package m3au_pkg;

  localparam int WORD_WIDTH    = 32;
  localparam int FRACTION_BITS = 16;
  localparam int ELEMENTS      = 9;
  localparam int IDX_W         = 4;
  localparam int PROD_W        = 2 * WORD_WIDTH;
  localparam int SUM_W         = WORD_WIDTH + 2;

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic [IDX_W-1:0]             idx_t;

  // Item operation codes
  localparam logic [1:0] OPER_LOAD_A = 2'd0;
  localparam logic [1:0] OPER_LOAD_B = 2'd1;
  localparam logic [1:0] OPER_EXEC   = 2'd2;

  // Compute codes
  localparam logic [2:0] COP_ADD    = 3'd0;
  localparam logic [2:0] COP_SUB    = 3'd1;
  localparam logic [2:0] COP_SCALE  = 3'd2;
  localparam logic [2:0] COP_MATMUL = 3'd3;
  localparam logic [2:0] COP_MATVEC = 3'd4;
  localparam logic [2:0] COP_TRANS  = 3'd5;

  localparam word_t WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  // Clamp a widened sum to the word range.
  function automatic word_t sat_sum(input sum_t x);
    word_t res;
    if (x > sum_t'(WORD_MAX)) begin
      res = WORD_MAX;
    end else if (x < sum_t'(WORD_MIN)) begin
      res = WORD_MIN;
    end else begin
      res = x[WORD_WIDTH-1:0];
    end
    return res;
  endfunction

  // Arithmetic shift by the fraction width, then clamp to the word range.
  function automatic word_t sat_prod(input prod_t p);
    prod_t sh;
    word_t res;
    sh = p >>> FRACTION_BITS;
    if (sh > prod_t'(WORD_MAX)) begin
      res = WORD_MAX;
    end else if (sh < prod_t'(WORD_MIN)) begin
      res = WORD_MIN;
    end else begin
      res = sh[WORD_WIDTH-1:0];
    end
    return res;
  endfunction

  // Column-major position col*3+row.
  function automatic idx_t pos3(input logic [1:0] col, input logic [1:0] row);
    return {1'b0, col, 1'b0} + {2'b00, col} + {2'b00, row};
  endfunction

endpackage

FILE: sv/matrix3x3_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// matrix3x3_arithmetic_unit: 3x3 Q16.16 matrix arithmetic over one shared MAC
// Loads write one element per transaction; an execute transaction streams
// the result matrix (or vector) out element by element with a last flag.
// ---------------------------------------------------------------------------
// Latency/throughput: a load transaction is taken while the unit is idle. An
//   execute runs fetch, multiply and accumulate steps per term (three terms per
//   element for matrix product and matrix-vector, one for the other ops) on the
//   single shared multiplier/adder, then holds each element until it is taken;
//   input stays stalled until the last element has been taken.
// Reset: rst_n (sync, active low) clears the sequencer; stored matrices keep
//   unknown contents until loaded.
module matrix3x3_arithmetic_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [3:0]  in_element_index,
  input  logic signed [31:0] in_element_value,
  input  logic [2:0]  in_compute_op,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_result_value,
  output logic [3:0]  out_result_index,
  output logic        out_last_result
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam m3au_pkg::idx_t LAST_ELEM = m3au_pkg::idx_t'(m3au_pkg::ELEMENTS - 1);
  localparam m3au_pkg::idx_t LAST_VEC  = m3au_pkg::idx_t'(2);

  // Element stores: written at the load index, read at one sequencer address.
  m3au_pkg::word_t mat_a_r [m3au_pkg::ELEMENTS];
  m3au_pkg::word_t mat_b_r [m3au_pkg::ELEMENTS];

  logic [2:0]      state_r, state_nxt;
  m3au_pkg::idx_t  elem_r, elem_nxt;     // result position
  logic [1:0]      row_r, row_nxt;
  logic [1:0]      col_r, col_nxt;
  logic [1:0]      k_r, k_nxt;           // dot-product term
  logic [2:0]      cop_r, cop_nxt;
  m3au_pkg::word_t scale_r, scale_nxt;
  m3au_pkg::word_t opa_r, opa_nxt;
  m3au_pkg::word_t opb_r, opb_nxt;
  m3au_pkg::prod_t prod_r, prod_nxt;
  m3au_pkg::word_t acc_r, acc_nxt;

  logic            in_acc;
  logic            load_a, load_b, exec_go;
  m3au_pkg::idx_t  a_idx, b_idx;
  logic            is_dot;
  logic            last_elem;
  m3au_pkg::prod_t mul_w;
  logic signed [m3au_pkg::WORD_WIDTH:0] add_x, add_y;
  m3au_pkg::sum_t  sum_w;

  // Input side is open only when no execute is in flight.
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign load_a  = in_acc && (in_operation == m3au_pkg::OPER_LOAD_A) &&
                   (in_element_index <= LAST_ELEM);
  assign load_b  = in_acc && (in_operation == m3au_pkg::OPER_LOAD_B) &&
                   (in_element_index <= LAST_ELEM);
  // Unused compute codes and operation codes produce nothing.
  assign exec_go = in_acc && (in_operation == m3au_pkg::OPER_EXEC) &&
                   (in_compute_op <= m3au_pkg::COP_TRANS);

  assign is_dot    = (cop_r == m3au_pkg::COP_MATMUL) || (cop_r == m3au_pkg::COP_MATVEC);
  assign last_elem = (cop_r == m3au_pkg::COP_MATVEC) ? (elem_r == LAST_VEC)
                                                     : (elem_r == LAST_ELEM);

  // Operand addressing per operation
  always_comb begin
    a_idx = elem_r;
    b_idx = elem_r;
    unique case (cop_r)
      m3au_pkg::COP_MATMUL: begin
        a_idx = m3au_pkg::pos3(k_r, row_r);
        b_idx = m3au_pkg::pos3(col_r, k_r);
      end
      m3au_pkg::COP_MATVEC: begin
        a_idx = m3au_pkg::pos3(k_r, row_r);
        b_idx = m3au_pkg::pos3(2'd0, k_r);
      end
      m3au_pkg::COP_TRANS: begin
        a_idx = m3au_pkg::pos3(row_r, col_r);
      end
      default: begin
        a_idx = elem_r;
        b_idx = elem_r;
      end
    endcase
  end

  // Shared multiplier (32x32 signed)
  assign mul_w = opa_r * opb_r;

  // Shared saturating adder: operands chosen by operation.
  always_comb begin
    add_x = '0;
    add_y = '0;
    unique case (cop_r)
      m3au_pkg::COP_ADD: begin
        add_x = {opa_r[31], opa_r};
        add_y = {opb_r[31], opb_r};
      end
      m3au_pkg::COP_SUB: begin
        add_x = {opa_r[31], opa_r};
        add_y = -{opb_r[31], opb_r};
      end
      m3au_pkg::COP_TRANS: begin
        add_x = {opa_r[31], opa_r};
      end
      default: begin
        // products: accumulate onto the running sum after the first term
        add_x = (k_r == 2'd0) ? '0 : {acc_r[31], acc_r};
        add_y = {1'b0, m3au_pkg::sat_prod(prod_r)};
        add_y[m3au_pkg::WORD_WIDTH] = add_y[m3au_pkg::WORD_WIDTH-1];
      end
    endcase
  end

  assign sum_w = {add_x[m3au_pkg::WORD_WIDTH], add_x} +
                 {add_y[m3au_pkg::WORD_WIDTH], add_y};

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    elem_nxt  = elem_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    k_nxt     = k_r;
    cop_nxt   = cop_r;
    scale_nxt = scale_r;
    opa_nxt   = opa_r;
    opb_nxt   = opb_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (exec_go) begin
          state_nxt = ST_FETCH;
          cop_nxt   = in_compute_op;
          scale_nxt = in_element_value;
          elem_nxt  = '0;
          row_nxt   = '0;
          col_nxt   = '0;
          k_nxt     = '0;
        end
      end
      ST_FETCH: begin
        opa_nxt   = mat_a_r[a_idx];
        opb_nxt   = (cop_r == m3au_pkg::COP_SCALE) ? scale_r : mat_b_r[b_idx];
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = mul_w;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt = m3au_pkg::sat_sum(sum_w);
        if (is_dot && (k_r != 2'd2)) begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (last_elem) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_FETCH;
            elem_nxt  = elem_r + m3au_pkg::idx_t'(1);
            k_nxt     = '0;
            if (row_r == 2'd2) begin
              row_nxt = '0;
              col_nxt = col_r + 2'd1;
            end else begin
              row_nxt = row_r + 2'd1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elem_r  <= elem_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    k_r     <= k_nxt;
    cop_r   <= cop_nxt;
    scale_r <= scale_nxt;
    opa_r   <= opa_nxt;
    opb_r   <= opb_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
  end

  // Element stores
  always_ff @(posedge clk) begin
    if (load_a) begin
      mat_a_r[in_element_index] <= in_element_value;
    end
    if (load_b) begin
      mat_b_r[in_element_index] <= in_element_value;
    end
  end

  // Result transaction straight from the accumulator register
  assign out_valid        = (state_r == ST_OUT);
  assign out_result_value = acc_r;
  assign out_result_index = elem_r;
  assign out_last_result  = last_elem;

endmodule

FILE: bench/tb_matrix3x3_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// tb_matrix3x3_arithmetic_unit: self-checking bench for the 3x3 matrix unit
// Loads both matrices, runs every compute op on edge values and random data
// under random gaps and output back-pressure, and checks every result element
// against a shadow copy of the matrices.
// ---------------------------------------------------------------------------
module tb_matrix3x3_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes the unit must ignore
  localparam logic [1:0] OPER_SPARE   = 2'd3;
  localparam logic [2:0] COP_SPARE_LO = 3'd6;
  localparam logic [2:0] COP_SPARE_HI = 3'd7;

  localparam int MAX_IDLE        = 13;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int TAIL_CYCLES     = 120;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS    = 160;

  typedef struct {
    m3au_pkg::word_t value;
    m3au_pkg::idx_t  index;
    logic            last;
  } elem_t;

  // DUT ports, all inputs known from time zero
  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              in_valid         = 1'b0;
  logic              in_stall;
  logic [1:0]        in_operation     = m3au_pkg::OPER_LOAD_A;
  logic [3:0]        in_element_index = '0;
  logic signed [31:0] in_element_value = '0;
  logic [2:0]        in_compute_op    = m3au_pkg::COP_ADD;
  logic              out_valid;
  logic              out_stall        = 1'b0;
  logic signed [31:0] out_result_value;
  logic [3:0]        out_result_index;
  logic              out_last_result;

  // Shadow copies of the two stored matrices
  m3au_pkg::word_t shadow_a [m3au_pkg::ELEMENTS];
  m3au_pkg::word_t shadow_b [m3au_pkg::ELEMENTS];

  // Result elements owed by the DUT, oldest first
  elem_t pending_elements [$];

  // Idle control shared by the sender, the receiver and the tests
  bit sender_idle   = 1'b1;
  bit receiver_idle = 1'b1;
  int hold_request  = 0;

  // Bookkeeping
  int errors          = 0;
  int items_sent      = 0;
  int loads_done      = 0;
  int results_checked = 0;
  int exec_count [6];
  int quiet_cycles    = 0;

  matrix3x3_arithmetic_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_element_index (in_element_index),
    .in_element_value (in_element_value),
    .in_compute_op    (in_compute_op),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_result_index (out_result_index),
    .out_last_result  (out_last_result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Fixed-point arithmetic, done in 64 bits and clamped to the word range
  // ------------------------------------------------------------------------
  function automatic m3au_pkg::word_t clamp_to_word(input longint x);
    m3au_pkg::word_t res;
    if (x > longint'(m3au_pkg::WORD_MAX)) begin
      res = m3au_pkg::WORD_MAX;
    end else if (x < longint'(m3au_pkg::WORD_MIN)) begin
      res = m3au_pkg::WORD_MIN;
    end else begin
      res = x[m3au_pkg::WORD_WIDTH-1:0];
    end
    return res;
  endfunction

  function automatic m3au_pkg::word_t q_add(input m3au_pkg::word_t a,
                                            input m3au_pkg::word_t b);
    return clamp_to_word(longint'(a) + longint'(b));
  endfunction

  function automatic m3au_pkg::word_t q_sub(input m3au_pkg::word_t a,
                                            input m3au_pkg::word_t b);
    return clamp_to_word(longint'(a) - longint'(b));
  endfunction

  // 32x32 fits in 64 bits; arithmetic shift truncates toward minus infinity
  function automatic m3au_pkg::word_t q_mul(input m3au_pkg::word_t a,
                                            input m3au_pkg::word_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp_to_word(p >>> m3au_pkg::FRACTION_BITS);
  endfunction

  // Row of A times a column vector, saturating after each partial sum
  function automatic m3au_pkg::word_t row_dot(input int row, input m3au_pkg::word_t v0,
                                              input m3au_pkg::word_t v1,
                                              input m3au_pkg::word_t v2);
    m3au_pkg::word_t acc;
    acc = q_mul(shadow_a[row], v0);
    acc = q_add(acc, q_mul(shadow_a[3 + row], v1));
    acc = q_add(acc, q_mul(shadow_a[6 + row], v2));
    return acc;
  endfunction

  // ------------------------------------------------------------------------
  // Apply one accepted transaction to the shadow matrices and queue the
  // result elements an execute owes.
  // ------------------------------------------------------------------------
  task automatic track_item(input logic [1:0] oper, input m3au_pkg::idx_t idx,
                            input m3au_pkg::word_t val, input logic [2:0] cop);
    m3au_pkg::word_t res [m3au_pkg::ELEMENTS];
    int    count;
    int    c;
    int    r;
    elem_t e;
    if (oper == m3au_pkg::OPER_LOAD_A || oper == m3au_pkg::OPER_LOAD_B) begin
      loads_done++;
      // out-of-range index is dropped by the unit
      if (idx < m3au_pkg::ELEMENTS) begin
        if (oper == m3au_pkg::OPER_LOAD_A) begin
          shadow_a[idx] = val;
        end else begin
          shadow_b[idx] = val;
        end
      end
    end else if (oper == m3au_pkg::OPER_EXEC && cop <= m3au_pkg::COP_TRANS) begin
      exec_count[cop]++;
      count = (cop == m3au_pkg::COP_MATVEC) ? 3 : m3au_pkg::ELEMENTS;
      for (int i = 0; i < count; i++) begin
        c = i / 3;
        r = i % 3;
        case (cop)
          m3au_pkg::COP_ADD:    res[i] = q_add(shadow_a[i], shadow_b[i]);
          m3au_pkg::COP_SUB:    res[i] = q_sub(shadow_a[i], shadow_b[i]);
          m3au_pkg::COP_SCALE:  res[i] = q_mul(shadow_a[i], val);
          m3au_pkg::COP_MATMUL: res[i] = row_dot(r, shadow_b[c*3], shadow_b[c*3+1],
                                                 shadow_b[c*3+2]);
          // vector is column 0 of B
          m3au_pkg::COP_MATVEC: res[i] = row_dot(i, shadow_b[0], shadow_b[1],
                                                 shadow_b[2]);
          default:              res[i] = shadow_a[r*3 + c];
        endcase
        e.value = res[i];
        e.index = m3au_pkg::idx_t'(i);
        e.last  = (i == count - 1);
        pending_elements.push_back(e);
      end
    end
    // operation 3 and compute ops 6/7 owe nothing
  endtask

  // ------------------------------------------------------------------------
  // Sender: optional random gap, then hold the transaction until accepted.
  // Valid stays high across back-to-back transactions.
  // ------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] oper, input m3au_pkg::idx_t idx,
                           input m3au_pkg::word_t val, input logic [2:0] cop);
    int gap;
    gap = sender_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= oper;
    in_element_index <= idx;
    in_element_value <= val;
    in_compute_op    <= cop;
    do @(posedge clk); while (in_stall);
    track_item(oper, idx, val, cop);
    items_sent++;
  endtask

  // Sender pause: drop valid and wait for every owed element.
  // The loop waits on the clock before testing, so valid is never lowered and raised in one step.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_elements.size() != 0);
  endtask

  // Q16.16 operand: half of them small values so products stay in range,
  // with rails and full-width noise mixed in
  function automatic m3au_pkg::word_t pick_value();
    m3au_pkg::word_t v;
    case ($urandom_range(0, 9))
      0:       v = m3au_pkg::WORD_MAX;
      1:       v = m3au_pkg::WORD_MIN;
      2:       v = '0;
      3, 4:    v = m3au_pkg::word_t'($urandom);
      default: v = m3au_pkg::word_t'($urandom_range(0, 524288)) - 32'sd262144;
    endcase
    return v;
  endfunction

  function automatic m3au_pkg::idx_t pick_index();
    m3au_pkg::idx_t idx;
    if ($urandom_range(0, 99) < 8) begin
      idx = m3au_pkg::idx_t'($urandom_range(m3au_pkg::ELEMENTS, 15));
    end else begin
      idx = m3au_pkg::idx_t'($urandom_range(0, m3au_pkg::ELEMENTS - 1));
    end
    return idx;
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Fill every element of both matrices; rails and unit values included.
  // Nothing may be executed on an unwritten element, so this runs first.
  task automatic test_load_both_matrices();
    send_item(m3au_pkg::OPER_LOAD_A, 4'd0, m3au_pkg::WORD_MAX, m3au_pkg::COP_ADD);
    send_item(m3au_pkg::OPER_LOAD_A, 4'd1, m3au_pkg::WORD_MIN, m3au_pkg::COP_TRANS);
    send_item(m3au_pkg::OPER_LOAD_A, 4'd2, 32'sh0001_0000,     m3au_pkg::COP_SUB);
    send_item(m3au_pkg::OPER_LOAD_A, 4'd3, 32'shFFFF_0000,     m3au_pkg::COP_SCALE);
    send_item(m3au_pkg::OPER_LOAD_A, 4'd4, 32'sh0000_0000,     m3au_pkg::COP_MATMUL);
    send_item(m3au_pkg::OPER_LOAD_A, 4'd5, 32'sh0001_8000,     m3au_pkg::COP_MATVEC);
    send_item(m3au_pkg::OPER_LOAD_A, 4'd6, 32'shFFFF_FFFF,     COP_SPARE_HI);
    send_item(m3au_pkg::OPER_LOAD_A, 4'd7, 32'sh7FFF_0000,     m3au_pkg::COP_ADD);
    send_item(m3au_pkg::OPER_LOAD_A, 4'd8, 32'sh0000_0001,     m3au_pkg::COP_ADD);
    send_item(m3au_pkg::OPER_LOAD_B, 4'd8, 32'shFFFF_0000,     m3au_pkg::COP_ADD);
    send_item(m3au_pkg::OPER_LOAD_B, 4'd7, 32'sh0001_0000,     m3au_pkg::COP_ADD);
    send_item(m3au_pkg::OPER_LOAD_B, 4'd6, 32'sh0000_0001,     m3au_pkg::COP_ADD);
    send_item(m3au_pkg::OPER_LOAD_B, 4'd5, 32'shFFFE_8000,     m3au_pkg::COP_ADD);
    send_item(m3au_pkg::OPER_LOAD_B, 4'd4, m3au_pkg::WORD_MIN, m3au_pkg::COP_ADD);
    send_item(m3au_pkg::OPER_LOAD_B, 4'd3, 32'sh0001_0000,     m3au_pkg::COP_ADD);
    send_item(m3au_pkg::OPER_LOAD_B, 4'd2, 32'sh0002_0000,     m3au_pkg::COP_ADD);
    send_item(m3au_pkg::OPER_LOAD_B, 4'd1, m3au_pkg::WORD_MAX, m3au_pkg::COP_ADD);
    send_item(m3au_pkg::OPER_LOAD_B, 4'd0, m3au_pkg::WORD_MAX, m3au_pkg::COP_ADD);
  endtask

  // Out-of-range load, spare operation and spare compute op: no effect.
  // The operations that follow read A and would expose a stray write.
  task automatic test_ignored_items();
    send_item(m3au_pkg::OPER_LOAD_A, 4'd15, 32'sh1234_5678, m3au_pkg::COP_ADD);
    send_item(OPER_SPARE,            4'd4,  m3au_pkg::WORD_MAX, m3au_pkg::COP_ADD);
    send_item(m3au_pkg::OPER_EXEC,   4'd0,  m3au_pkg::WORD_MIN, COP_SPARE_HI);
  endtask

  // Every compute op once, scale twice; saturation on both rails comes from the loads
  task automatic test_each_operation();
    send_item(m3au_pkg::OPER_EXEC, 4'd0, '0,                 m3au_pkg::COP_ADD);
    send_item(m3au_pkg::OPER_EXEC, 4'd9, '0,                 m3au_pkg::COP_SUB);
    send_item(m3au_pkg::OPER_EXEC, 4'd0, 32'sh0001_0000,     m3au_pkg::COP_SCALE);
    send_item(m3au_pkg::OPER_EXEC, 4'd0, m3au_pkg::WORD_MIN, m3au_pkg::COP_SCALE);
    send_item(m3au_pkg::OPER_EXEC, 4'd0, '0,                 m3au_pkg::COP_MATMUL);
    send_item(m3au_pkg::OPER_EXEC, 4'd0, '0,                 m3au_pkg::COP_MATVEC);
    send_item(m3au_pkg::OPER_EXEC, 4'd0, '0,                 m3au_pkg::COP_TRANS);
    wait_drained();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // back to back, so the unit fills and stalls its input.
  task automatic test_output_backpressure();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    hold_request  = HOLD_OFF_CYCLES;
    send_item(m3au_pkg::OPER_EXEC,   4'd0, '0,           m3au_pkg::COP_MATMUL);
    send_item(m3au_pkg::OPER_LOAD_B, 4'd4, pick_value(), m3au_pkg::COP_ADD);
    send_item(m3au_pkg::OPER_EXEC,   4'd0, '0,           m3au_pkg::COP_ADD);
    send_item(m3au_pkg::OPER_EXEC,   4'd0, pick_value(), m3au_pkg::COP_SCALE);
    send_item(m3au_pkg::OPER_LOAD_A, 4'd0, pick_value(), m3au_pkg::COP_ADD);
    send_item(m3au_pkg::OPER_EXEC,   4'd0, '0,           m3au_pkg::COP_MATVEC);
    send_item(m3au_pkg::OPER_EXEC,   4'd0, '0,           m3au_pkg::COP_TRANS);
    wait_drained();
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  // Random loads and executes; idle settings change every few dozen steps,
  // and now and then the sender pauses until the unit has drained.
  task automatic test_random_mix();
    int             counted;
    int             step;
    int             pick;
    m3au_pkg::idx_t idx;
    logic [2:0]     cop;
    counted = 0;
    step    = 0;
    while (counted < RANDOM_ITEMS) begin
      if (step % 30 == 0) begin
        sender_idle   = ($urandom_range(0, 3) != 0);
        receiver_idle = ($urandom_range(0, 3) != 0);
      end
      if (step % 70 == 69) begin
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        idx = pick_index();
        send_item((pick < 25) ? m3au_pkg::OPER_LOAD_A : m3au_pkg::OPER_LOAD_B, idx,
                  pick_value(), 3'($urandom_range(0, 7)));
        if (idx < m3au_pkg::ELEMENTS) begin
          counted++;
        end
      end else if (pick < 88) begin
        cop = 3'($urandom_range(m3au_pkg::COP_ADD, m3au_pkg::COP_TRANS));
        send_item(m3au_pkg::OPER_EXEC, m3au_pkg::idx_t'($urandom_range(0, 15)),
                  pick_value(), cop);
        counted++;
      end else if (pick < 94) begin
        cop = ($urandom_range(0, 1) != 0) ? COP_SPARE_HI : COP_SPARE_LO;
        send_item(m3au_pkg::OPER_EXEC, m3au_pkg::idx_t'($urandom_range(0, 15)),
                  m3au_pkg::word_t'($urandom), cop);
      end else begin
        send_item(OPER_SPARE, m3au_pkg::idx_t'($urandom_range(0, 15)),
                  m3au_pkg::word_t'($urandom), 3'($urandom_range(0, 7)));
      end
      step++;
    end
  endtask

  // ------------------------------------------------------------------------
  // Receiver: after each accepted result a random stall, or a long hold-off
  // when a test asks for one. One nonblocking write of out_stall per edge.
  // ------------------------------------------------------------------------
  initial begin : receiver
    int wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        wait_left    = hold_request;
        hold_request = 0;
      end else if (out_valid && !out_stall) begin
        wait_left = receiver_idle ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (wait_left > 0) begin
        out_stall <= 1'b1;
        wait_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(input string field, input longint want, input longint got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Checker: every accepted result transaction against the oldest owed element
  always @(posedge clk) begin : check_result
    elem_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_elements.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual value %0d index %0d last %0b",
                 $time, out_result_value, out_result_index, out_last_result);
      end else begin
        want = pending_elements.pop_front();
        results_checked++;
        if (out_result_value !== want.value) begin
          report_mismatch("result_value", want.value, out_result_value);
        end
        if (out_result_index !== want.index) begin
          report_mismatch("result_index", want.index, out_result_index);
        end
        if (out_last_result !== want.last) begin
          report_mismatch("last_result", want.last, out_last_result);
        end
      end
    end
  end

  // Watchdog: cycles since the last transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d elements still owed", $time,
               quiet_cycles, pending_elements.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------
  initial begin
    foreach (exec_count[i]) exec_count[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_load_both_matrices();
    test_ignored_items();
    test_each_operation();
    test_output_backpressure();
    test_random_mix();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_elements.size() != 0) begin
      $display("%0t: %0d result elements never arrived", $time, pending_elements.size());
      errors += pending_elements.size();
    end

    $display("Ran %0d input transactions (%0d loads) and checked %0d result elements",
             items_sent, loads_done, results_checked);
    $display("Executes: add %0d, sub %0d, scale %0d, product %0d, mat-vec %0d, transpose %0d",
             exec_count[m3au_pkg::COP_ADD], exec_count[m3au_pkg::COP_SUB],
             exec_count[m3au_pkg::COP_SCALE], exec_count[m3au_pkg::COP_MATMUL],
             exec_count[m3au_pkg::COP_MATVEC], exec_count[m3au_pkg::COP_TRANS]);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/m3au_pkg.sv
sv/matrix3x3_arithmetic_unit.sv
bench/tb_matrix3x3_arithmetic_unit.sv
